// File: rtl/core/assert_macros.svh
// Assertion macros used by the lookup table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SILT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SILT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/silt_pkg.sv
// Types and constants of the sorted interval lookup table.
`default_nettype none

package silt_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 256;
	localparam int unsigned IDX_OUT_W       = 8;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_FIND = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [63:0] byte_offset;
		logic [63:0] range_size;
	} in_t;

	typedef struct packed {
		logic                 found;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [63:0]          first_start;
		logic                 add_dropped;
	} out_t;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] size;
	} entry_t;

endpackage

`default_nettype wire

// File: rtl/core/silt_stream_if.sv
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface silt_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sorted_interval_lookup_table_unit.sv
// Sorted interval lookup table: range inserts and binary-search lookups.
//
// Channels: req (sink, silt_pkg::in_t) carries one command a beat: kind add
// inserts the range (byte_offset, range_size) after all stored ranges with the
// same start; kind find searches for the range holding byte_offset. rsp
// (source, silt_pkg::out_t) returns exactly one beat per command, in order:
// found/entry_index for finds, add_dropped for an add into a full table, and
// first_start, the smallest stored start (0 while empty).
// Timing: one command at a time. A find reads and compares one entry for each
// probe of the search (at most log2(MAX_ENTRIES)+1 probes); a hit goes straight
// to the result and a miss passes one more read state first. An add reads and
// compares the entries above its slot one by one, shifting each up by one, then
// writes the new range into the gap; a dropped add goes straight to the result.
// Every probe and every shift is one registered read of the entry memory and
// one compare. A new command is taken as soon as the sequencer is idle, in the
// cycle after the previous result is loaded, while that result may still sit in
// the output register. When rsp stalls, a finished result waits in the sequencer
// until the output register frees up.
// Reset empties the table at once (entry count cleared, no clearing pass);
// the entry memory itself is not cleared and is only read below the count.
`default_nettype none
`include "assert_macros.svh"

module sorted_interval_lookup_table_unit #(
	parameter int unsigned MAX_ENTRIES = silt_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	silt_stream_if.sink   req,
	silt_stream_if.source rsp
);
	import silt_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = IDX_W + 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ADD_RD  = 3'd1;
	localparam logic [2:0] ST_ADD_CMP = 3'd2;
	localparam logic [2:0] ST_LK_RD   = 3'd3;
	localparam logic [2:0] ST_LK_CMP  = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	// Entry memory and its ports
	entry_t             mem [MAX_ENTRIES];
	entry_t             rd_data_q;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_ra;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	entry_t             mem_wd;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;
	logic [63:0]        off_q;
	logic [63:0]        len_q;
	logic [63:0]        first_q;
	logic               res_found_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_drop_q;
	logic               rsp_valid_q;
	out_t               rsp_data_q;

	logic [CNT_W-1:0]   mid_c;
	logic               holds_c;
	logic               above_c;
	logic               slot_free_c;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.data    = rsp_data_q;
	assign slot_free_c = !rsp_valid_q || rsp.ready;

	// Probe index of the search; hi_q holds one past the upper bound
	assign mid_c   = lo_q + ((hi_q - CNT_W'(1) - lo_q) >> 1);
	assign holds_c = (off_q >= rd_data_q.start) && ((off_q - rd_data_q.start) < rd_data_q.size);
	assign above_c = rd_data_q.start > off_q;

	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '{start: off_q, size: len_q};
		case (state_q)
			ST_ADD_RD: begin
				if (lo_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					mem_ra = IDX_W'(lo_q - CNT_W'(1));
				end
			end
			ST_ADD_CMP: begin
				// Shift the larger entry up, or drop the new one into the gap
				mem_we = 1'b1;
				mem_wa = lo_q[IDX_W-1:0];
				if (above_c) begin
					mem_wd = rd_data_q;
				end
			end
			ST_LK_RD: begin
				if (lo_q < hi_q) begin
					mem_re = 1'b1;
					mem_ra = mid_c[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			off_q <= req.data.byte_offset;
			len_q <= req.data.range_size;
		end
		if (state_q == ST_ADD_RD && lo_q == '0) begin
			first_q <= off_q;
		end
		if (state_q == ST_LK_RD) begin
			mid_q <= mid_c[IDX_W-1:0];
		end
		if (state_q == ST_LK_CMP && holds_c) begin
			res_idx_q <= mid_q;
		end
		if (state_q == ST_EMIT && slot_free_c) begin
			rsp_data_q.found       <= res_found_q;
			rsp_data_q.entry_index <= res_found_q ? IDX_OUT_W'(res_idx_q) : '0;
			rsp_data_q.first_start <= (count_q != '0) ? first_q : '0;
			rsp_data_q.add_dropped <= res_drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			res_found_q <= 1'b0;
			res_drop_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						res_found_q <= 1'b0;
						res_drop_q  <= 1'b0;
						if (req.data.kind == KIND_ADD) begin
							if (count_q == CNT_W'(MAX_ENTRIES)) begin
								res_drop_q <= 1'b1;
								state_q    <= ST_EMIT;
							end else begin
								lo_q    <= count_q;
								state_q <= ST_ADD_RD;
							end
						end else begin
							lo_q    <= '0;
							hi_q    <= count_q;
							state_q <= ST_LK_RD;
						end
					end
				end
				ST_ADD_RD: begin
					if (lo_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_ADD_CMP;
					end
				end
				ST_ADD_CMP: begin
					if (above_c) begin
						lo_q    <= lo_q - CNT_W'(1);
						state_q <= ST_ADD_RD;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_LK_RD: begin
					state_q <= (lo_q < hi_q) ? ST_LK_CMP : ST_EMIT;
				end
				ST_LK_CMP: begin
					if (holds_c) begin
						res_found_q <= 1'b1;
						state_q     <= ST_EMIT;
					end else begin
						if (above_c) begin
							hi_q <= CNT_W'(mid_q);
						end else begin
							lo_q <= CNT_W'(mid_q) + CNT_W'(1);
						end
						state_q <= ST_LK_RD;
					end
				end
				ST_EMIT: begin
					if (slot_free_c) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SILT_ASSERT_IMP(a_probe_in_table, state_q == ST_LK_CMP, CNT_W'(mid_q) < count_q, "lookup probe beyond stored entries")
	`SILT_ASSERT_IMP(a_drop_only_full, state_q == ST_EMIT && res_drop_q, count_q == CNT_W'(MAX_ENTRIES) && !res_found_q, "add dropped while table not full")
	`SILT_ASSERT_IMP(a_write_in_range, mem_we, CNT_W'(mem_wa) <= count_q && count_q < CNT_W'(MAX_ENTRIES), "entry write outside table")
	`SILT_ASSERT_NXT(a_count_steps, state_q == ST_EMIT, count_q == $past(count_q), "entry count changed while emitting")

endmodule

`default_nettype wire

// File: dv/tb_sorted_interval_lookup_table_unit.sv
// Testbench of the sorted interval lookup table: directed and random adds and lookups.
`default_nettype none

module tb_sorted_interval_lookup_table_unit;
	import silt_pkg::*;

	localparam int DEPTH       = MAX_ENTRIES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 600;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	silt_stream_if #(.data_t(in_t))  req_if ();
	silt_stream_if #(.data_t(out_t)) rsp_if ();

	sorted_interval_lookup_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Shadow copy of the range table.
	logic [63:0] tbl_start [DEPTH];
	logic [63:0] tbl_size  [DEPTH];
	int          tbl_count = 0;

	out_t expected_rsp_q [$];
	out_t rsp_want;
	int   mismatch_cnt = 0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   stall_cnt = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_t make_cmd(logic kind, logic [63:0] off, logic [63:0] size);
		in_t c;
		c.kind        = kind;
		c.byte_offset = off;
		c.range_size  = size;
		return c;
	endfunction

	// Apply one command to the shadow table and return the beat it should produce.
	function automatic out_t table_apply(in_t cmd);
		out_t res;
		int   pos;
		int   i;
		int   lo;
		int   hi;
		int   mid;
		res = '0;
		if (cmd.kind == KIND_ADD) begin
			if (tbl_count >= DEPTH) begin
				res.add_dropped = 1'b1;
			end else begin
				pos = tbl_count;
				while (pos > 0 && tbl_start[pos-1] > cmd.byte_offset)
					pos--;
				for (i = tbl_count; i > pos; i--) begin
					tbl_start[i] = tbl_start[i-1];
					tbl_size[i]  = tbl_size[i-1];
				end
				tbl_start[pos] = cmd.byte_offset;
				tbl_size[pos]  = cmd.range_size;
				tbl_count++;
			end
		end else begin
			lo = 0;
			hi = tbl_count - 1;
			while (lo <= hi && !res.found) begin
				mid = lo + (hi - lo) / 2;
				if (cmd.byte_offset >= tbl_start[mid] &&
				    (cmd.byte_offset - tbl_start[mid]) < tbl_size[mid]) begin
					res.found       = 1'b1;
					res.entry_index = mid[IDX_OUT_W-1:0];
				end else if (tbl_start[mid] > cmd.byte_offset) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
		end
		res.first_start = (tbl_count > 0) ? tbl_start[0] : 64'd0;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatch_cnt++;
		$display("[%0t] mismatch %s: got 0x%h, want 0x%h", $time, what, got, want);
	endtask

	// Drive one command beat and record its expected response once accepted.
	task automatic send_cmd(in_t cmd);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= cmd;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		expected_rsp_q.push_back(table_apply(cmd));
	endtask

	// Response checker and receiver back-pressure.
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected beat", rsp_if.data.first_start, 64'd0);
			end else begin
				rsp_want = expected_rsp_q.pop_front();
				if (rsp_if.data.found !== rsp_want.found)
					report_mismatch("found", 64'(rsp_if.data.found), 64'(rsp_want.found));
				if (rsp_if.data.entry_index !== rsp_want.entry_index)
					report_mismatch("entry_index", 64'(rsp_if.data.entry_index),
						64'(rsp_want.entry_index));
				if (rsp_if.data.first_start !== rsp_want.first_start)
					report_mismatch("first_start", rsp_if.data.first_start,
						rsp_want.first_start);
				if (rsp_if.data.add_dropped !== rsp_want.add_dropped)
					report_mismatch("add_dropped", 64'(rsp_if.data.add_dropped),
						64'(rsp_want.add_dropped));
			end
		end
		rsp_if.ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("sorted_interval_lookup_table_unit verification failed");
				$finish;
			end
		end
	end

	task automatic test_empty_lookup();
		send_cmd(make_cmd(KIND_FIND, 64'd0, 64'd0));
		send_cmd(make_cmd(KIND_FIND, ALL_ONES, ALL_ONES));
		send_cmd(make_cmd(KIND_FIND, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
	endtask

	task automatic test_range_edges();
		send_cmd(make_cmd(KIND_ADD, 64'h1000, 64'h100));
		// Offset below the lowest start: search ends at index zero without a hit.
		send_cmd(make_cmd(KIND_FIND, 64'hFFF, 64'd0));
		send_cmd(make_cmd(KIND_FIND, 64'h1000, 64'd0));
		send_cmd(make_cmd(KIND_FIND, 64'h10FF, 64'd0));
		send_cmd(make_cmd(KIND_FIND, 64'h1100, 64'd0));
		// Zero-size range holds nothing.
		send_cmd(make_cmd(KIND_ADD, 64'h2000, 64'd0));
		send_cmd(make_cmd(KIND_FIND, 64'h2000, ALL_ONES));
		// Ranges whose end would not fit in 64 bits.
		send_cmd(make_cmd(KIND_ADD, ALL_ONES, ALL_ONES));
		send_cmd(make_cmd(KIND_FIND, ALL_ONES, 64'd0));
		send_cmd(make_cmd(KIND_ADD, 64'h8000_0000_0000_0000, ALL_ONES));
		send_cmd(make_cmd(KIND_FIND, ALL_ONES - 64'd1, 64'd0));
	endtask

	task automatic test_duplicate_starts();
		send_cmd(make_cmd(KIND_ADD, 64'h1000, 64'h10));
		send_cmd(make_cmd(KIND_ADD, 64'h1000, 64'h200));
		send_cmd(make_cmd(KIND_FIND, 64'h1050, 64'd0));
		send_cmd(make_cmd(KIND_ADD, 64'd0, 64'd1));
		send_cmd(make_cmd(KIND_FIND, 64'd0, 64'd0));
		send_cmd(make_cmd(KIND_FIND, 64'h1000, 64'd0));
	endtask

	function automatic logic [63:0] pick_start();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 64'($urandom_range(24'hFF_FFFF));
		if (r < 75 && tbl_count > 0)
			return tbl_start[$urandom_range(tbl_count - 1)];
		if (r < 90)
			return rand64();
		case ($urandom_range(3))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return ALL_ONES - 64'd1;
			default: return 64'h8000_0000_0000_0000;
		endcase
	endfunction

	function automatic logic [63:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 64'($urandom_range(4096, 1));
		if (r < 80)
			return 64'd0;
		if (r < 92)
			return rand64();
		return ALL_ONES;
	endfunction

	// Mostly offsets inside or at the edges of stored ranges.
	function automatic logic [63:0] pick_offset();
		int          r;
		int          idx;
		logic [63:0] s;
		logic [63:0] z;
		r = $urandom_range(99);
		if (tbl_count == 0 || r < 10)
			return rand64();
		idx = $urandom_range(tbl_count - 1);
		s   = tbl_start[idx];
		z   = tbl_size[idx];
		if (r < 70)
			return (z == 64'd0) ? s : s + (rand64() % z);
		if (r < 80)
			return s + z - 64'd1;
		if (r < 90)
			return s + z;
		return s - 64'd1;
	endfunction

	task automatic test_random_traffic(int n_items);
		int   i;
		int   r;
		in_t  cmd;
		for (i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				cmd = make_cmd(KIND_ADD, pick_start(), pick_size());
			else if (r < 95)
				cmd = make_cmd(KIND_FIND, pick_offset(), rand64());
			else
				cmd = make_cmd(logic'($urandom_range(1)), rand64(), rand64());
			send_cmd(cmd);
		end
	endtask

	initial begin
		send_idle = 21;
		recv_idle = 57;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookup();
		test_range_edges();
		test_duplicate_starts();
		test_random_traffic(430);

		send_idle = 57;
		recv_idle = 21;
		test_random_traffic(450);

		send_idle = 0;
		recv_idle = 0;
		test_random_traffic(450);
		req_if.valid <= 1'b0;

		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_rsp_q.size() != 0)
			report_mismatch("missing beats", 64'(expected_rsp_q.size()), 64'd0);

		if (mismatch_cnt == 0)
			$display("sorted_interval_lookup_table_unit verification clean");
		else
			$display("sorted_interval_lookup_table_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/silt_pkg.sv
rtl/core/silt_stream_if.sv
rtl/core/sorted_interval_lookup_table_unit.sv
dv/tb_sorted_interval_lookup_table_unit.sv
